FILE: rtl/core/rfd_pkg.sv
// Shared types and constants for the response frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package rfd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD   = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  MAX_PAY_RESET = 8'd255;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic [7:0] payload_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  max_payload;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/rfd_if.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface rfd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] byte_value;
  modport source (output valid, output req_type, output byte_value, input ready);
  modport sink (input valid, input req_type, input byte_value, output ready);
endinterface

interface rfd_rsp_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic [7:0] payload_count;
  logic       last;
  modport source (output valid, output out_kind, output payload_byte, output status,
                  output payload_count, output last, input ready);
  modport sink (input valid, input out_kind, input payload_byte, input status,
                input payload_count, input last, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rfd_cfg.sv
// Configuration register file for the response frame deframer.
`timescale 1ns / 1ps
`default_nettype none
module rfd_cfg
  import rfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TIMEOUT_RESET;
      cfg_q.max_payload   <= MAX_PAY_RESET;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= wr_data_i;
        CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= wr_data_i[7:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/rfd_parser.sv
// Frame phase tracking, checksums, timeout counting and result formation.
`timescale 1ns / 1ps
`default_nettype none
module rfd_parser
  import rfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] byte_value_i,
  input  cfg_t            cfg_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_PRE  = 4'd1;
  localparam logic [3:0] PH_SC0  = 4'd2;
  localparam logic [3:0] PH_SC1  = 4'd3;
  localparam logic [3:0] PH_LEN  = 4'd4;
  localparam logic [3:0] PH_LCS  = 4'd5;
  localparam logic [3:0] PH_TFI  = 4'd6;
  localparam logic [3:0] PH_CMD  = 4'd7;
  localparam logic [3:0] PH_PAY  = 4'd8;
  localparam logic [3:0] PH_DCS  = 4'd9;

  localparam logic [7:0] SYNC_LO    = 8'h00;
  localparam logic [7:0] SYNC_HI    = 8'hFF;
  localparam logic [7:0] TFI_TO_HOST = 8'hD5;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  dlv_q, dlv_d;

  logic        fin;
  logic [1:0]  fin_status;
  logic [16:0] tick_inc;
  logic [7:0]  len_rem;
  logic [7:0]  left_dec;
  logic [7:0]  sum_add;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    len_d       = len_q;
    left_d      = left_q;
    sum_d       = sum_q;
    dlv_d       = dlv_q;
    fin         = 1'b0;
    fin_status  = ST_OK;
    res_valid_o = 1'b0;
    res_o       = '0;
    tick_inc    = {1'b0, tick_q} + 17'd1;
    len_rem     = len_q - MIN_LENGTH;
    left_dec    = left_q - 8'd1;
    sum_add     = sum_q + byte_value_i;

    if (accept_i) begin
      if (req_type_i == REQ_START) begin
        phase_d = PH_PRE;
        tick_d  = '0;
        len_d   = '0;
        left_d  = '0;
        sum_d   = '0;
        dlv_d   = '0;
      end else if (phase_q == PH_IDLE || phase_q > PH_DCS) begin
        phase_d = phase_q;
      end else if (req_type_i == REQ_TICK) begin
        if (tick_inc > {1'b0, cfg_i.timeout_ticks}) begin
          fin        = 1'b1;
          fin_status = (phase_q == PH_SC0 || phase_q == PH_SC1) ? ST_INVALID : ST_TIMEOUT;
        end else begin
          tick_d = tick_inc[15:0];
        end
      end else if (req_type_i == REQ_BYTE) begin
        tick_d = '0;
        case (phase_q)
          PH_PRE: begin
            if (byte_value_i != SYNC_LO) begin
              fin        = 1'b1;
              fin_status = ST_TIMEOUT;
            end else begin
              phase_d = PH_SC0;
            end
          end
          PH_SC0: begin
            if (byte_value_i != SYNC_LO) begin
              fin        = 1'b1;
              fin_status = ST_INVALID;
            end else begin
              phase_d = PH_SC1;
            end
          end
          PH_SC1: begin
            if (byte_value_i != SYNC_HI) begin
              fin        = 1'b1;
              fin_status = ST_INVALID;
            end else begin
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            len_d   = byte_value_i;
            phase_d = PH_LCS;
          end
          PH_LCS: begin
            if ((len_q + byte_value_i) != 8'd0 || len_q < MIN_LENGTH) begin
              fin        = 1'b1;
              fin_status = ST_INVALID;
            end else begin
              phase_d = PH_TFI;
            end
          end
          PH_TFI: begin
            if (byte_value_i != TFI_TO_HOST) begin
              fin        = 1'b1;
              fin_status = ST_INVALID;
            end else begin
              sum_d   = byte_value_i;
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            sum_d   = sum_add;
            left_d  = len_rem;
            phase_d = (len_rem == 8'd0) ? PH_DCS : PH_PAY;
          end
          PH_PAY: begin
            sum_d  = sum_add;
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              phase_d = PH_DCS;
            end
            if (dlv_q < cfg_i.max_payload) begin
              dlv_d                = dlv_q + 8'd1;
              res_valid_o          = 1'b1;
              res_o.out_kind       = KIND_PAYLOAD;
              res_o.payload_byte   = byte_value_i;
              res_o.status         = ST_OK;
              res_o.payload_count  = dlv_q + 8'd1;
              res_o.last           = 1'b0;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = (sum_add != 8'd0) ? ST_INVALID : ST_OK;
          end
        endcase
      end
    end

    if (fin) begin
      res_valid_o         = 1'b1;
      res_o.out_kind      = KIND_STATUS;
      res_o.payload_byte  = '0;
      res_o.status        = fin_status;
      res_o.payload_count = dlv_q;
      res_o.last          = 1'b1;
      phase_d             = PH_IDLE;
      tick_d              = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      len_q   <= '0;
      left_q  <= '0;
      sum_q   <= '0;
      dlv_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      dlv_q   <= dlv_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rfd_outq.sv
// Two-entry result queue between the parser and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module rfd_outq
  import rfd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   push_data_i,
  output logic      space_o,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output result_t   pop_data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign space_o     = (cnt_q != 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/response_frame_deframer_top.sv
// Top level of the response frame deframer: config registers, parser and result queue.
// Results: each result is written into the result queue when its request is accepted and is offered from there.
// Throughput: one request transaction per cycle while the two-entry result queue has room.
// A stalled result channel holds the request side once both queue entries are full.
// Reset: asynchronous, active low; parser idle, queue empty, timeout 1000, max payload 255.
`timescale 1ns / 1ps
`default_nettype none
module response_frame_deframer_top
  import rfd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfd_req_if.sink   req_i,
  rfd_rsp_if.source rsp_o,
  rfd_cfg_if.sink   cfg_i
);

  cfg_t    cfg;
  logic    space;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t head;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = space;
  assign accept      = req_i.valid && space;

  rfd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  rfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_i.req_type),
    .byte_value_i (req_i.byte_value),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rfd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .pop_valid_o (rsp_o.valid),
    .pop_ready_i (rsp_o.ready),
    .pop_data_o  (head)
  );

  assign rsp_o.out_kind      = head.out_kind;
  assign rsp_o.payload_byte  = head.payload_byte;
  assign rsp_o.status        = head.status;
  assign rsp_o.payload_count = head.payload_count;
  assign rsp_o.last          = head.last;

endmodule
`default_nettype wire
